### src/jerk_limited_velocity_profiler_defines.svh
// Assertion macros for the jerk-limited velocity profiler.
// Used by the controller and divider modules.
`ifndef JERK_LIMITED_VELOCITY_PROFILER_DEFINES_SVH
`define JERK_LIMITED_VELOCITY_PROFILER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define JLVP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define JLVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/jlvp_pkg.sv
// Shared types and constants for the jerk-limited velocity profiler.
// No dependencies.
package jlvp_pkg;

	localparam int REG_W    = 31;
	localparam int IDX_W    = 2;
	localparam int DT_W     = 16;
	localparam int OUT_W    = 32;
	localparam int QUOT_BITS = 49; // quotient saturates at 2^48

	typedef enum logic [IDX_W-1:0] {
		REG_MAX_VEL  = 2'd0,
		REG_MAX_ACC  = 2'd1,
		REG_MAX_DEC  = 2'd2,
		REG_MAX_JERK = 2'd3
	} reg_idx_t;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV1,
		ST_ACC1,
		ST_DIV2,
		ST_JERK,
		ST_MULJ,
		ST_ACC2,
		ST_MULA,
		ST_FIN,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch input item
		logic prep;      // clamp target, pick limit, form first dividend
		logic div_start; // load divider
		logic div_step;  // one quotient bit
		logic acc1;      // clamp desired acceleration, form second dividend
		logic jerk;      // clamp jerk
		logic mulj;      // acc + jerk*dt
		logic mula;      // vel + acc*dt, saturate
		logic fin;       // overshoot / rest snap, commit state
		logic load;      // preset velocity
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic is_load;
		logic dt_zero;
	} sts_t;

endpackage

### src/jerk_limited_velocity_profiler.sv
// Jerk-limited S-curve velocity shaper, top level.
// Channels: input item (cmd, target_velocity, time_step) on in_valid/in_ready;
// result item (velocity, acceleration) on out_valid/out_ready; both valid/ready.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one of four limits per cycle,
// index 0 velocity, 1 acceleration, 2 deceleration, 3 jerk. No read-back.
// Write limits only while idle.
// Sequence: a load item or a zero time step goes from acceptance through the
// prep state straight to the result. A profile step runs two divisions
// through one restoring divider, one quotient bit a cycle over VALUE_WIDTH+17
// bits each, then the jerk, integration and finishing states before its result.
// Throughput: one item at a time; the next item is accepted the cycle after
// the result is taken. The divider loop dominates the time of a step item.
// Stall: the result holds on the outputs while out_ready is low.
// Reset: limits return to 1.0/1.0/2.0/4.0, velocity and acceleration to zero.
// Depends on jlvp_pkg, jlvp_ctrl, jlvp_dp, jlvp_div.
module jerk_limited_velocity_profiler #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jlvp_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [jlvp_pkg::REG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic signed [jlvp_pkg::OUT_W-1:0] target_velocity,
	input  logic [jlvp_pkg::DT_W-1:0]         time_step,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [jlvp_pkg::OUT_W-1:0] velocity,
	output logic signed [jlvp_pkg::OUT_W-1:0] acceleration
);
	import jlvp_pkg::*;

	cmd_t cmd_w;
	sts_t sts_w;

	// sequencer: walks one item through prep, two divides, integrate, finish
	jlvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd_o     (cmd_w),
		.sts       (sts_w)
	);

	// datapath: limits, state, shared divider and multiplier
	jlvp_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_i           (cmd_w),
		.sts             (sts_w),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.target_velocity (target_velocity),
		.time_step       (time_step),
		.velocity        (velocity),
		.acceleration    (acceleration)
	);
endmodule

### src/jlvp_ctrl.sv
// Controller state machine of the velocity profiler.
// Depends on jlvp_pkg and the defines header.
`include "jerk_limited_velocity_profiler_defines.svh"
module jlvp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output jlvp_pkg::cmd_t  cmd_o,
	input  jlvp_pkg::sts_t  sts
);
	import jlvp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PREP;
			ST_PREP: begin
				if (sts.is_load || sts.dt_zero) state_d = ST_OUT;
				else state_d = ST_DIV1;
			end
			ST_DIV1: if (sts.div_done) state_d = ST_ACC1;
			ST_ACC1: state_d = ST_DIV2;
			ST_DIV2: if (sts.div_done) state_d = ST_JERK;
			ST_JERK: state_d = ST_MULJ;
			ST_MULJ: state_d = ST_ACC2;
			ST_ACC2: state_d = ST_MULA;
			ST_MULA: state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_o     = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd_o.capture = in_valid;
			end
			ST_PREP: begin
				cmd_o.prep      = 1'b1;
				cmd_o.load      = sts.is_load;
				cmd_o.div_start = !sts.is_load && !sts.dt_zero;
			end
			ST_DIV1: cmd_o.div_step = !sts.div_done;
			ST_ACC1: begin
				cmd_o.acc1      = 1'b1;
				cmd_o.div_start = 1'b1;
			end
			ST_DIV2: cmd_o.div_step = !sts.div_done;
			ST_JERK: cmd_o.jerk = 1'b1;
			ST_MULJ: cmd_o.mulj = 1'b1;
			ST_ACC2: cmd_o.mulj = 1'b0;
			ST_MULA: cmd_o.mula = 1'b1;
			ST_FIN:  cmd_o.fin  = 1'b1;
			ST_OUT:  out_valid  = 1'b1;
			default: cmd_o = '0;
		endcase
	end

	`JLVP_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE, "ready outside idle")
	`JLVP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`JLVP_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready, "accept while result pending")
endmodule

### src/jlvp_div.sv
// Shared restoring divider, one quotient bit a cycle.
// Computes (mag << 16) / dt with saturation at 2^48. Depends on jlvp_pkg.
`include "jerk_limited_velocity_profiler_defines.svh"
module jlvp_div #(
	parameter int NUM_W = 33
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        step,
	input  logic [NUM_W-1:0]            mag,
	input  logic [jlvp_pkg::DT_W-1:0]   dt,
	output logic                        done,
	output logic [jlvp_pkg::QUOT_BITS-1:0] quot
);
	import jlvp_pkg::*;

	localparam int DIVD_W = NUM_W + DT_W;
	localparam int CNT_W  = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] divd_q;
	logic [DT_W:0]     rem_q;
	logic [DT_W-1:0]   dt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DT_W:0]     trial;
	logic [DT_W:0]     diff;

	assign trial = {rem_q[DT_W-1:0], divd_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dt_q};
	assign done  = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIVD_W);
		end else if (step && !done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divd_q <= {mag, {DT_W{1'b0}}};
			rem_q  <= '0;
			dt_q   <= dt;
		end else if (step && !done) begin
			if (!diff[DT_W]) begin
				rem_q  <= diff;
				divd_q <= {divd_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				divd_q <= {divd_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	// quotient bits shift into divd_q; saturate above 2^48
	always_comb begin
		if (DIVD_W > QUOT_BITS - 1 && |(divd_q >> (QUOT_BITS - 1))
				&& (divd_q != (DIVD_W'(1) << (QUOT_BITS - 1)))) begin
			quot = QUOT_BITS'(1) << (QUOT_BITS - 1);
		end else begin
			quot = QUOT_BITS'(divd_q);
		end
	end

	`JLVP_ASSERT_NEXT(a_div_load, clk, arst_n, start, !done, "divider did not load")
endmodule

### src/jlvp_dp.sv
// Datapath of the velocity profiler: registers, clamps, divider, multiplier.
// Depends on jlvp_pkg and jlvp_div.
module jlvp_dp #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jlvp_pkg::cmd_t                cmd_i,
	output jlvp_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [jlvp_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [jlvp_pkg::REG_W-1:0]    cfg_wdata,
	input  logic                          cmd,
	input  logic signed [jlvp_pkg::OUT_W-1:0] target_velocity,
	input  logic [jlvp_pkg::DT_W-1:0]     time_step,
	output logic signed [jlvp_pkg::OUT_W-1:0] velocity,
	output logic signed [jlvp_pkg::OUT_W-1:0] acceleration
);
	import jlvp_pkg::*;

	localparam int VW = VALUE_WIDTH;
	// wide working width: covers 2^48 quotient and differences
	localparam int WW = (VW + 2 > QUOT_BITS + 1) ? VW + 2 : QUOT_BITS + 1;
	localparam int NUM_W = VW + 1;
	localparam logic signed [WW-1:0] REST_EPS =
		WW'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [WW-1:0] SIGN_EPS =
		WW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [WW-1:0] VAL_MAX = WW'((65'sd1 <<< (VW - 1)) - 1);
	localparam logic signed [WW-1:0] VAL_MIN = -VAL_MAX - 1;

	// config
	logic [REG_W-1:0] vmax_q, amax_q, dmax_q, jmax_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmax_q <= REG_W'(65536);
			amax_q <= REG_W'(65536);
			dmax_q <= REG_W'(131072);
			jmax_q <= REG_W'(262144);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MAX_VEL:  vmax_q <= cfg_wdata;
				REG_MAX_ACC:  amax_q <= cfg_wdata;
				REG_MAX_DEC:  dmax_q <= cfg_wdata;
				REG_MAX_JERK: jmax_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	function automatic logic signed [WW-1:0] lim_reg(input logic [REG_W-1:0] r);
		logic signed [WW-1:0] v;
		v = WW'({1'b0, r});
		lim_reg = (v > VAL_MAX) ? VAL_MAX : v;
	endfunction

	function automatic logic signed [WW-1:0] clamp(input logic signed [WW-1:0] x,
			input logic signed [WW-1:0] l);
		if (x > l) clamp = l;
		else if (x < -l) clamp = -l;
		else clamp = x;
	endfunction

	function automatic logic signed [WW-1:0] absw(input logic signed [WW-1:0] x);
		absw = x[WW-1] ? -x : x;
	endfunction

	function automatic logic [1:0] sband(input logic signed [WW-1:0] x);
		if (x > SIGN_EPS) sband = 2'b01;
		else if (x < -SIGN_EPS) sband = 2'b11;
		else sband = 2'b00;
	endfunction

	// item and working registers
	logic                 cmd_q;
	logic signed [WW-1:0] req_q, tgt_q, lim_q, jerk_q, vel_q, acc_q, work_q;
	logic signed [WW-1:0] pvel_q, pacc_q;
	logic [DT_W-1:0]      dt_q;
	logic                 neg_q;
	logic [NUM_W-1:0]     div_mag;

	logic                 div_done;
	logic [QUOT_BITS-1:0] quot;
	logic signed [WW-1:0] quot_s;

	jlvp_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd_i.div_start),
		.step   (cmd_i.div_step),
		.mag    (div_mag),
		.dt     (dt_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign quot_s = neg_q ? -WW'(quot) : WW'(quot);

	// shared multiplier: |x| * dt >> 16 with sign restored
	logic signed [WW-1:0] mul_in;
	logic [VW-1:0]        mul_mag;
	logic [VW+DT_W-1:0]   mul_prod;
	logic signed [WW-1:0] mul_res;
	assign mul_in   = cmd_i.mulj ? jerk_q : acc_q;
	assign mul_mag  = VW'(absw(mul_in));
	assign mul_prod = mul_mag * dt_q;
	assign mul_res  = mul_in[WW-1] ? -WW'(mul_prod >> DT_W) : WW'(mul_prod >> DT_W);

	// prep combinational
	logic signed [WW-1:0] tgt_c, lim_c, d1_c, d2_c, want_c;
	logic                 decel_c;
	always_comb begin
		tgt_c = clamp(req_q, lim_reg(vmax_q));
		if (pvel_q > REST_EPS && tgt_c < 0) tgt_c = '0;
		else if (pvel_q < -REST_EPS && tgt_c > 0) tgt_c = '0;
		decel_c = (tgt_c == 0) ||
			(absw(tgt_c) < absw(pvel_q) && sband(tgt_c) == sband(pvel_q));
		lim_c  = decel_c ? lim_reg(dmax_q) : lim_reg(amax_q);
		d1_c   = tgt_c - pvel_q;
		want_c = clamp(quot_s, lim_q);
		d2_c   = want_c - pacc_q;
	end

	// dividend magnitude goes straight into the divider on its load cycle
	assign div_mag = cmd_i.prep ? NUM_W'(absw(d1_c)) : NUM_W'(absw(d2_c));

	// finishing combinational
	logic signed [WW-1:0] vf, af;
	always_comb begin
		vf = vel_q;
		af = acc_q;
		if (!tgt_q[WW-1]) begin
			if (vf > tgt_q) begin vf = tgt_q; af = '0; end
		end else begin
			if (vf < tgt_q) begin vf = tgt_q; af = '0; end
		end
		if (tgt_q == 0 && absw(vf) < REST_EPS) begin
			vf = '0;
			af = '0;
		end
	end

	logic signed [WW-1:0] vsum;
	assign vsum = pvel_q + mul_res;

	always_ff @(posedge clk) begin
		if (cmd_i.capture) begin
			cmd_q <= cmd;
			req_q <= WW'(target_velocity);
			dt_q  <= time_step;
		end
		if (cmd_i.prep) begin
			tgt_q  <= tgt_c;
			lim_q  <= lim_c;
			neg_q  <= d1_c[WW-1];
		end
		if (cmd_i.acc1) begin
			neg_q  <= d2_c[WW-1];
		end
		if (cmd_i.jerk) jerk_q <= clamp(quot_s, lim_reg(jmax_q));
		if (cmd_i.mulj) work_q <= pacc_q + mul_res;
		if (cmd_i.mula) vel_q <= (vsum > VAL_MAX) ? VAL_MAX :
			((vsum < VAL_MIN) ? VAL_MIN : vsum);
	end

	// acc_q loads pacc_q at prep and clamped work_q in the cycle after mulj
	always_ff @(posedge clk) begin
		if (cmd_i.prep) acc_q <= pacc_q;
		else if (!cmd_i.mulj && !cmd_i.mula && !cmd_i.fin && !cmd_i.div_step
				&& !cmd_i.acc1 && !cmd_i.jerk && !cmd_i.capture && !cmd_i.div_start)
			acc_q <= clamp(work_q, lim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvel_q <= '0;
			pacc_q <= '0;
		end else if (cmd_i.load) begin
			pvel_q <= clamp(req_q, lim_reg(vmax_q));
			pacc_q <= '0;
		end else if (cmd_i.fin) begin
			pvel_q <= vf;
			pacc_q <= af;
		end
	end

	assign sts.div_done = div_done;
	assign sts.is_load  = (cmd_q == CMD_LOAD);
	assign sts.dt_zero  = (dt_q == '0);

	assign velocity     = OUT_W'(pvel_q);
	assign acceleration = OUT_W'(pacc_q);
endmodule
